[rtl/core/rotary_position_embedding_assert.svh]
// assertion macros for the rotary position embedding core
// expects signals named clk and rst in the scope of each use
`ifndef ROTARY_POSITION_EMBEDDING_ASSERT_SVH
`define ROTARY_POSITION_EMBEDDING_ASSERT_SVH

// same-cycle implication, masked during reset
`define RPE_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define RPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds around reset
`define RPE_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/rope_pkg.sv]
// shared widths, fixed-point constants, latencies and register codes
// for the rotary position embedding core; no dependencies
package rope_pkg;

  // register file
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_DIM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG2_BASE = 2'd1;

  localparam int HD_W  = 9;
  localparam int LB_W  = 22;
  localparam int IDX_W = 7;

  localparam logic [HD_W-1:0] HD_RESET = 9'd128;
  localparam logic [LB_W-1:0] LB_RESET = 22'd870823;

  // datapath widths
  localparam int NUM_W = 30;  // 2 * index * log2 base
  localparam int E_W   = 22;  // exponent, Q6.16
  localparam int F_W   = 16;  // exponent fraction
  localparam int IP_W  = 6;   // exponent integer part
  localparam int G_W   = 33;  // inverse frequency, Q32 up to one
  localparam int X_W   = 31;  // sin/cos argument, Q30
  localparam int SC_W  = 32;  // signed sin/cos, Q30

  // fixed-point constants
  localparam logic [31:0] LN2_Q32     = 32'd2977044472;
  localparam logic [34:0] TWO_PI_Q32  = 35'd26986075410;
  localparam logic [32:0] HALF_PI_Q32 = 33'd6746518852;
  localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

  // unit latencies in cycles
  localparam int DIV_STEPS = 4;
  localparam int DIV_LAT   = 6;
  localparam int EXP_LAT   = 38;
  localparam int SC_LAT    = 33;

endpackage

[rtl/core/rope_delay.sv]
// enable-gated delay line for side data riding along the pipeline
// standalone, no package use
module rope_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         ce,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [DEPTH];

  // shift on every advance of the pipeline
  always_ff @(posedge clk) begin
    if (ce) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

[rtl/core/rope_cdiv.sv]
// two-stage floor division by a constant: reciprocal multiply, then one
// correction step; standalone, no package use
module rope_cdiv #(
  parameter int VW = 33,
  parameter int D  = 3
) (
  input  logic          clk,
  input  logic          ce,
  input  logic [VW-1:0] v,
  output logic [VW-1:0] q
);

  localparam logic [VW:0] RECIP = (VW+1)'((65'd1 << VW) / D);

  logic [2*VW:0] prod;
  logic [VW-1:0] v1;
  logic [VW-1:0] q0;
  logic [VW-1:0] rem;

  // estimate, low by at most one
  always_ff @(posedge clk) begin
    if (ce) begin
      prod <= v * RECIP;
      v1   <= v;
    end
  end

  assign q0  = prod[2*VW-1:VW];
  assign rem = v1 - VW'(q0 * VW'(D));

  // fix up the estimate
  always_ff @(posedge clk) begin
    if (ce) begin
      q <= (rem >= VW'(D)) ? q0 + 1'b1 : q0;
    end
  end

endmodule

[rtl/core/rope_ediv.sv]
// pipelined restoring divider for the frequency exponent 2*i*L / head dimension
// uses rope_pkg; up to four quotient bits per stage
module rope_ediv (
  input  logic                      clk,
  input  logic                      ce,
  input  logic [rope_pkg::NUM_W-1:0] num,
  input  logic [rope_pkg::HD_W-1:0]  hd,
  output logic [rope_pkg::E_W-1:0]   e
);
  import rope_pkg::*;

  logic [HD_W-1:0] rem [DIV_LAT+1];
  logic [E_W-1:0]  nq  [DIV_LAT+1];
  logic [HD_W-1:0] dv  [DIV_LAT+1];

  // the top bits lie below the divisor whenever the item is in range
  assign rem[0] = HD_W'(num[NUM_W-1:E_W]);
  assign nq[0]  = num[E_W-1:0];
  assign dv[0]  = hd;

  for (genvar s = 0; s < DIV_LAT; s++) begin : g_stage
    logic [HD_W-1:0] r_c;
    logic [E_W-1:0]  n_c;
    logic [HD_W:0]   t_c;

    // a few shift-subtract steps
    always_comb begin
      r_c = rem[s];
      n_c = nq[s];
      t_c = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
        if (s * DIV_STEPS + i < E_W) begin
          t_c = {r_c, n_c[E_W-1]};
          if (t_c >= {1'b0, dv[s]}) begin
            r_c = HD_W'(t_c - {1'b0, dv[s]});
            n_c = {n_c[E_W-2:0], 1'b1};
          end else begin
            r_c = t_c[HD_W-1:0];
            n_c = {n_c[E_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem[s+1] <= r_c;
        nq[s+1]  <= n_c;
        dv[s+1]  <= dv[s];
      end
    end
  end

  assign e = nq[DIV_LAT];

endmodule

[rtl/core/rope_exp.sv]
// inverse frequency 2^-frac as exp(-frac*ln2): thirteen-term series,
// three stages per term; uses rope_pkg, rope_cdiv, rope_delay
module rope_exp (
  input  logic                     clk,
  input  logic                     ce,
  input  logic [rope_pkg::F_W-1:0] f,
  output logic [rope_pkg::G_W-1:0] g
);
  import rope_pkg::*;

  localparam int TERMS = 12;

  logic [47:0] xp;
  logic [31:0] xr;

  logic [G_W-1:0]     t_c [TERMS+1];
  logic signed [35:0] s_c [TERMS+1];
  logic [31:0]        x_c [TERMS+1];

  // series argument in q32
  assign xp = 48'(f) * 48'(LN2_Q32);

  always_ff @(posedge clk) begin
    if (ce) begin
      xr <= xp[47:16];
    end
  end

  assign t_c[0] = ONE_Q32;
  assign s_c[0] = '0;
  assign x_c[0] = xr;

  for (genvar k = 1; k <= TERMS; k++) begin : g_term
    logic [64:0]        p_c;
    logic [G_W-1:0]     pa;
    logic signed [35:0] sa;
    logic [31:0]        xa;
    logic [67:0]        side_q;

    assign p_c = 65'(t_c[k-1]) * 65'(x_c[k-1]);

    // multiply by the argument, fold the previous term into the sum
    always_ff @(posedge clk) begin
      if (ce) begin
        pa <= p_c[64:32];
        xa <= x_c[k-1];
        if (k % 2 == 0) begin
          sa <= s_c[k-1] - $signed({3'b000, t_c[k-1]});
        end else begin
          sa <= s_c[k-1] + $signed({3'b000, t_c[k-1]});
        end
      end
    end

    rope_cdiv #(.VW(G_W), .D(k)) u_div (
      .clk (clk),
      .ce  (ce),
      .v   (pa),
      .q   (t_c[k])
    );

    rope_delay #(.W(68), .DEPTH(2)) u_side (
      .clk (clk),
      .ce  (ce),
      .d   ({xa, sa}),
      .q   (side_q)
    );

    assign x_c[k] = side_q[67:36];
    assign s_c[k] = $signed(side_q[35:0]);
  end

  // last term, then clamp at zero
  logic signed [35:0] sf;
  assign sf = s_c[TERMS] + $signed({3'b000, t_c[TERMS]});

  always_ff @(posedge clk) begin
    if (ce) begin
      g <= sf[35] ? '0 : sf[G_W-1:0];
    end
  end

endmodule

[rtl/core/rope_angle.sv]
// angle = (position * inverse frequency) >> int_part, reduced modulo two pi by
// shifted compare-subtract stages, then split into quadrant and remainder
// uses rope_pkg
module rope_angle #(
  parameter int PW = 16
) (
  input  logic                      clk,
  input  logic                      ce,
  input  logic [PW-1:0]             pos,
  input  logic [rope_pkg::G_W-1:0]  g,
  input  logic [rope_pkg::IP_W-1:0] ip,
  output logic [rope_pkg::X_W-1:0]  x,
  output logic [1:0]                q
);
  import rope_pkg::*;

  localparam int AW   = PW + G_W;
  localparam int NRED = PW - 1;
  localparam logic [34:0] TWO_HALF = 35'(HALF_PI_Q32) << 1;
  localparam logic [34:0] ONE_HALF = 35'(HALF_PI_Q32);

  logic [AW-1:0]   prod;
  logic [IP_W-1:0] ip1;
  logic [AW-1:0]   a_c [NRED+1];

  // scale and shift
  always_ff @(posedge clk) begin
    if (ce) begin
      prod   <= AW'(pos) * AW'(g);
      ip1    <= ip;
      a_c[0] <= prod >> ip1;
    end
  end

  // one multiple of two pi per stage, largest first
  for (genvar i = 0; i < NRED; i++) begin : g_red
    localparam logic [AW-1:0] SUB = AW'(TWO_PI_Q32) << (NRED - 1 - i);
    always_ff @(posedge clk) begin
      if (ce) begin
        a_c[i+1] <= (a_c[i] >= SUB) ? a_c[i] - SUB : a_c[i];
      end
    end
  end

  // quadrant split; the sliver just under two pi lands in quadrant three
  logic [34:0] a35;
  logic [34:0] r1;
  logic        q1;
  logic        h0;
  logic [34:0] rq;

  assign a35 = a_c[NRED][34:0];

  always_ff @(posedge clk) begin
    if (ce) begin
      q1 <= (a35 >= TWO_HALF);
      r1 <= (a35 >= TWO_HALF) ? a35 - TWO_HALF : a35;
    end
  end

  assign h0 = (r1 >= ONE_HALF);
  assign rq = h0 ? r1 - ONE_HALF : r1;

  always_ff @(posedge clk) begin
    if (ce) begin
      x <= rq[32:2];
      q <= {q1, h0};
    end
  end

endmodule

[rtl/core/rope_sincos.sv]
// sine and cosine of the reduced angle: nine-term series, four stages per
// term, then clamp and quadrant placement; uses rope_pkg, rope_cdiv, rope_delay
module rope_sincos (
  input  logic                            clk,
  input  logic                            ce,
  input  logic [rope_pkg::X_W-1:0]        x,
  input  logic [1:0]                      q,
  output logic signed [rope_pkg::SC_W-1:0] sn,
  output logic signed [rope_pkg::SC_W-1:0] cs
);
  import rope_pkg::*;

  localparam int TERMS = 8;
  localparam int TW    = 33;
  localparam int SW    = 34;
  localparam int BW    = X_W + 2 + 2 * SW;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  logic [TW-1:0]      st_c [TERMS+1];
  logic [TW-1:0]      ct_c [TERMS+1];
  logic signed [SW-1:0] ss_c [TERMS+1];
  logic signed [SW-1:0] cc_c [TERMS+1];
  logic [X_W-1:0]     x_c  [TERMS+1];
  logic [1:0]         q_c  [TERMS+1];

  assign st_c[0] = TW'(x);
  assign ct_c[0] = TW'(ONE_Q30);
  assign ss_c[0] = '0;
  assign cc_c[0] = '0;
  assign x_c[0]  = x;
  assign q_c[0]  = q;

  for (genvar k = 1; k <= TERMS; k++) begin : g_term
    logic [63:0]          sp_c, cp_c, sp2_c, cp2_c;
    logic [TW-1:0]        sm, cm, sm2, cm2;
    logic [X_W-1:0]       xa;
    logic [1:0]           qa;
    logic signed [SW-1:0] sa, ca;
    logic [BW-1:0]        side_q;

    assign sp_c = 64'(st_c[k-1]) * 64'(x_c[k-1]);
    assign cp_c = 64'(ct_c[k-1]) * 64'(x_c[k-1]);

    // first power of the argument, previous terms into the sums
    always_ff @(posedge clk) begin
      if (ce) begin
        sm <= sp_c[62:30];
        cm <= cp_c[62:30];
        xa <= x_c[k-1];
        qa <= q_c[k-1];
        if (k % 2 == 0) begin
          sa <= ss_c[k-1] - $signed({1'b0, st_c[k-1]});
          ca <= cc_c[k-1] - $signed({1'b0, ct_c[k-1]});
        end else begin
          sa <= ss_c[k-1] + $signed({1'b0, st_c[k-1]});
          ca <= cc_c[k-1] + $signed({1'b0, ct_c[k-1]});
        end
      end
    end

    assign sp2_c = 64'(sm) * 64'(xa);
    assign cp2_c = 64'(cm) * 64'(xa);

    // second power of the argument
    always_ff @(posedge clk) begin
      if (ce) begin
        sm2 <= sp2_c[62:30];
        cm2 <= cp2_c[62:30];
      end
    end

    rope_cdiv #(.VW(TW), .D((2 * k) * (2 * k + 1))) u_sdiv (
      .clk (clk),
      .ce  (ce),
      .v   (sm2),
      .q   (st_c[k])
    );

    rope_cdiv #(.VW(TW), .D((2 * k - 1) * (2 * k))) u_cdiv (
      .clk (clk),
      .ce  (ce),
      .v   (cm2),
      .q   (ct_c[k])
    );

    rope_delay #(.W(BW), .DEPTH(3)) u_side (
      .clk (clk),
      .ce  (ce),
      .d   ({xa, qa, sa, ca}),
      .q   (side_q)
    );

    assign x_c[k]  = side_q[BW-1:BW-X_W];
    assign q_c[k]  = side_q[2*SW+1:2*SW];
    assign ss_c[k] = $signed(side_q[2*SW-1:SW]);
    assign cc_c[k] = $signed(side_q[SW-1:0]);
  end

  // last terms, clamp to [0, 1], place into the quadrant
  logic signed [SW-1:0] sf, cf;
  logic [X_W-1:0]       s0, c0;
  logic signed [SC_W-1:0] sp, cp;

  assign sf = ss_c[TERMS] + $signed({1'b0, st_c[TERMS]});
  assign cf = cc_c[TERMS] + $signed({1'b0, ct_c[TERMS]});

  always_comb begin
    if (sf < 0) begin
      s0 = '0;
    end else if (sf > $signed(SW'(ONE_Q30))) begin
      s0 = ONE_Q30;
    end else begin
      s0 = sf[X_W-1:0];
    end
    if (cf < 0) begin
      c0 = '0;
    end else if (cf > $signed(SW'(ONE_Q30))) begin
      c0 = ONE_Q30;
    end else begin
      c0 = cf[X_W-1:0];
    end
    sp = $signed({1'b0, s0});
    cp = $signed({1'b0, c0});
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      case (q_c[TERMS])
        QUAD_0: begin
          sn <= sp;
          cs <= cp;
        end
        QUAD_1: begin
          sn <= cp;
          cs <= -sp;
        end
        QUAD_2: begin
          sn <= -sp;
          cs <= -cp;
        end
        default: begin
          sn <= -cp;
          cs <= sp;
        end
      endcase
    end
  end

endmodule

[rtl/core/rotary_position_embedding.sv]
// rotary position embedding, rotate-half form, one element pair per word
// throughput: one word per cycle; the whole pipeline holds while an output word waits
// an input word passes the entry stage, the exponent divider, the exp series, the angle
// reduction, the sin/cos series, the rotation products and the output word register
// reset clears all valid bits and restores head_dimension 128 and log2 base 870823
`include "rotary_position_embedding_assert.svh"

module rotary_position_embedding #(
  parameter int MAX_HEAD_DIM   = 256,
  parameter int VALUE_WIDTH    = 16,
  parameter int POSITION_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  // first_value, second_value, pair_index, token_position
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [((2*VALUE_WIDTH+7+POSITION_WIDTH+7)/8)*8-1:0] s_tdata,
  // rotated_first, rotated_second
  output logic m_tvalid,
  input  logic m_tready,
  output logic [((2*VALUE_WIDTH+7)/8)*8-1:0] m_tdata,
  // rejected
  output logic m_tuser,
  // register write channel
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [rope_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rope_pkg::LB_W-1:0] cfg_data
);
  import rope_pkg::*;

  localparam int VW      = VALUE_WIDTH;
  localparam int PW      = POSITION_WIDTH;
  localparam int OUT_W   = ((2*VW+7)/8)*8;
  localparam int ANG_LAT = PW + 3;
  localparam int SIDE_LAT = DIV_LAT + EXP_LAT + ANG_LAT + SC_LAT;
  localparam int TOT     = SIDE_LAT + 3;

  logic ce;
  logic [TOT-1:0] vld;

  logic [HD_W-1:0] head_dimension;
  logic [LB_W-1:0] log2_frequency_base;
  logic            regs_at_reset;

  // registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_dimension      <= HD_RESET;
      log2_frequency_base <= LB_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HEAD_DIM:  head_dimension      <= cfg_data[HD_W-1:0];
        CFG_LOG2_BASE: log2_frequency_base <= cfg_data;
        default: ;
      endcase
    end
  end

  assign regs_at_reset = (head_dimension == HD_RESET) && (log2_frequency_base == LB_RESET);

  // pipeline advance and valid bits
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;
  assign m_tvalid = vld[TOT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[TOT-2:0], s_tvalid};
    end
  end

  // input word fields
  logic signed [VW-1:0] fv, sv;
  logic [IDX_W-1:0]     idx;
  logic [PW-1:0]        pos;
  logic                 rej_c;

  assign fv  = $signed(s_tdata[VW-1:0]);
  assign sv  = $signed(s_tdata[2*VW-1:VW]);
  assign idx = s_tdata[2*VW+IDX_W-1:2*VW];
  assign pos = s_tdata[2*VW+IDX_W+PW-1:2*VW+IDX_W];

  assign rej_c = head_dimension[0] || (head_dimension == '0) ||
                 (int'(head_dimension) > MAX_HEAD_DIM) ||
                 ({1'b0, idx} >= head_dimension[HD_W-1:1]);

  // entry stage: exponent numerator and pass-through check
  logic [NUM_W-1:0] num0;
  logic [HD_W-1:0]  hd0;
  logic [PW-1:0]    pos0;
  logic signed [VW-1:0] x0_0, x1_0;
  logic             rej0;

  always_ff @(posedge clk) begin
    if (ce) begin
      num0 <= NUM_W'({idx, 1'b0}) * NUM_W'(log2_frequency_base);
      hd0  <= head_dimension;
      pos0 <= pos;
      x0_0 <= fv;
      x1_0 <= sv;
      rej0 <= rej_c;
    end
  end

  // exponent
  logic [E_W-1:0] e;

  rope_ediv u_ediv (
    .clk (clk),
    .ce  (ce),
    .num (num0),
    .hd  (hd0),
    .e   (e)
  );

  // inverse frequency
  logic [G_W-1:0] g;

  rope_exp u_exp (
    .clk (clk),
    .ce  (ce),
    .f   (e[F_W-1:0]),
    .g   (g)
  );

  logic [PW-1:0]      pos_e;
  logic [PW+IP_W-1:0] pip_g;

  rope_delay #(.W(PW), .DEPTH(DIV_LAT)) u_pos_dly (
    .clk (clk),
    .ce  (ce),
    .d   (pos0),
    .q   (pos_e)
  );

  rope_delay #(.W(PW+IP_W), .DEPTH(EXP_LAT)) u_pip_dly (
    .clk (clk),
    .ce  (ce),
    .d   ({pos_e, e[E_W-1:F_W]}),
    .q   (pip_g)
  );

  // angle reduction
  logic [X_W-1:0] ax;
  logic [1:0]     aq;

  rope_angle #(.PW(PW)) u_angle (
    .clk (clk),
    .ce  (ce),
    .pos (pip_g[PW+IP_W-1:IP_W]),
    .g   (g),
    .ip  (pip_g[IP_W-1:0]),
    .x   (ax),
    .q   (aq)
  );

  // sine and cosine
  logic signed [SC_W-1:0] sn, cs;

  rope_sincos u_sincos (
    .clk (clk),
    .ce  (ce),
    .x   (ax),
    .q   (aq),
    .sn  (sn),
    .cs  (cs)
  );

  // values and flag ride alongside
  logic [2*VW:0] side_q;

  rope_delay #(.W(2*VW+1), .DEPTH(SIDE_LAT)) u_side_dly (
    .clk (clk),
    .ce  (ce),
    .d   ({rej0, x1_0, x0_0}),
    .q   (side_q)
  );

  // rotation products
  logic signed [VW-1:0]    x0d, x1d;
  logic signed [VW+31:0]   p00, p11, p01, p10;
  logic signed [VW-1:0]    x0p, x1p;
  logic                    rejp;

  assign x0d = $signed(side_q[VW-1:0]);
  assign x1d = $signed(side_q[2*VW-1:VW]);

  always_ff @(posedge clk) begin
    if (ce) begin
      p00  <= x0d * cs;
      p11  <= x1d * sn;
      p01  <= x0d * sn;
      p10  <= x1d * cs;
      x0p  <= x0d;
      x1p  <= x1d;
      rejp <= side_q[2*VW];
    end
  end

  // round half up from q40 to q10 and saturate
  localparam logic signed [VW+32:0] SAT_HI = $signed({{34{1'b0}}, {(VW-1){1'b1}}});
  localparam logic signed [VW+32:0] SAT_LO = $signed({{34{1'b1}}, {(VW-1){1'b0}}});
  localparam logic signed [VW+32:0] HALF_LSB = $signed((VW+33)'(1 << 29));

  function automatic logic [VALUE_WIDTH-1:0] round_sat(input logic signed [VALUE_WIDTH+32:0] v);
    logic signed [VALUE_WIDTH+32:0] r;
    r = (v + HALF_LSB) >>> 30;
    if (r > SAT_HI) begin
      return SAT_HI[VALUE_WIDTH-1:0];
    end else if (r < SAT_LO) begin
      return SAT_LO[VALUE_WIDTH-1:0];
    end
    return r[VALUE_WIDTH-1:0];
  endfunction

  logic signed [VW+32:0] y0s, y1s;
  logic [VW-1:0] y0, y1;
  logic          rej_o;

  assign y0s = p00 - p11;
  assign y1s = p01 + p10;

  // output word register
  always_ff @(posedge clk) begin
    if (ce) begin
      y0    <= rejp ? x0p : round_sat(y0s);
      y1    <= rejp ? x1p : round_sat(y1s);
      rej_o <= rejp;
    end
  end

  assign m_tdata = OUT_W'({y1, y0});
  assign m_tuser = rej_o;

  // checks
  `RPE_ASSERT_NEXT(a_hold_on_stall, !ce, $stable(vld), "valid bits moved during a stall")
  `RPE_ASSERT_RST(a_reset_empty, rst, !m_tvalid, "output word valid right after reset")
  `RPE_ASSERT_RST(a_reset_regs, rst, regs_at_reset, "registers not at reset values")

endmodule
